FILE: hdl/gfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants and types for the gyro frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 4;
   localparam int Z_W     = 16;
   localparam int RATE_W  = 23;
   localparam int PITCH_W = 19;

   localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h55;
   localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h52;
   // 0x55 + 0x52, mod 256
   localparam logic [BYTE_W-1:0] SUM_SEED  = 8'hA7;

   localparam logic [IDX_W-1:0] Z_LO_IDX  = 4'd4;
   localparam logic [IDX_W-1:0] Z_HI_IDX  = 4'd5;
   localparam logic [IDX_W-1:0] CHECK_IDX = 4'd8;

   localparam logic [RATE_W-1:0] RATE_GAIN = 23'd125;

   typedef struct packed {
      logic           good;  // checksum matched on this beat
      logic [Z_W-1:0] z;     // assembled z word
   } gfp_frame_type;

endpackage

FILE: hdl/gfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_parser
// Header hunt, type check, payload collection and checksum for one byte/beat.
// ----------------------------------------------------------------------------
module gfp_parser
   import gfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_vld,
   input  logic [BYTE_W-1:0] byte_in,
   output gfp_frame_type     frame
);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [Z_W-1:0]    z_ff, z_in;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      z_in     = z_ff;
      case (phase_ff)
         PH_TYPE: begin
            if (byte_in == TYPE_BYTE) begin
               phase_in = PH_DATA;
               idx_in   = '0;
               sum_in   = SUM_SEED;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            if (idx_ff != CHECK_IDX) begin
               if (idx_ff == Z_LO_IDX) z_in[7:0]  = byte_in;
               if (idx_ff == Z_HI_IDX) z_in[15:8] = byte_in;
               sum_in = sum_ff + byte_in;
               idx_in = idx_ff + 1'b1;
            end else begin
               phase_in = PH_HUNT;
               idx_in   = '0;
            end
         end
         default: begin
            phase_in = (byte_in == HDR_BYTE) ? PH_TYPE : PH_HUNT;
         end
      endcase
   end

   assign frame.good = byte_vld && (phase_ff == PH_DATA) && (idx_ff == CHECK_IDX)
                       && (byte_in == sum_ff);
   assign frame.z    = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         idx_ff   <= '0;
         sum_ff   <= '0;
         z_ff     <= '0;
      end else if (byte_vld) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         z_ff     <= z_in;
      end
   end

endmodule

FILE: hdl/gfp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_out_stage
// Scales z to rate and pitch and holds the result beat until taken.
// ----------------------------------------------------------------------------
module gfp_out_stage
   import gfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  gfp_frame_type             frame,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [Z_W-1:0]     rsp_gyro_z_raw,
   output logic signed [RATE_W-1:0]  rsp_yaw_rate,
   output logic signed [PITCH_W-1:0] rsp_pitch_value
);

   logic                      vld_ff, vld_in;
   logic        [Z_W-1:0]     z_ff;
   logic        [RATE_W-1:0]  rate_ff, rate_in;
   logic        [PITCH_W-1:0] pitch_ff, pitch_in, z_p;
   logic        [RATE_W-1:0]  z_r;

   assign z_r      = {{(RATE_W-Z_W){frame.z[Z_W-1]}}, frame.z};
   assign z_p      = {{(PITCH_W-Z_W){frame.z[Z_W-1]}}, frame.z};
   assign rate_in  = z_r * RATE_GAIN;
   // -(5z) as -(4z + z)
   assign pitch_in = '0 - ((z_p << 2) + z_p);

   always_comb begin
      vld_in = vld_ff;
      if (frame.good)     vld_in = 1'b1;
      else if (rsp_ready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (frame.good) begin
         z_ff     <= frame.z;
         rate_ff  <= rate_in;
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_gyro_z_raw  = z_ff;
   assign rsp_yaw_rate    = rate_ff;
   assign rsp_pitch_value = pitch_ff;

endmodule

FILE: hdl/imu_gyro_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gyro_frame_parser_core
// Byte-stream parser for 0x55 0x52 angular-rate frames with 8-bit sum check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. A byte is captured in an input register,
// parsed once the result register can take a beat, and a frame with a good
// checksum loads the result register. The input keeps taking a byte every
// cycle as long as the result register is empty or being drained; a waiting
// result that is not taken holds the input register and then req_ready drops.
// Results: raw z, z*125 (11 fraction bits, deg/s) and -z*5 (14 fraction bits).
// Bad frames produce no beat.
module imu_gyro_frame_parser_core
   import gfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [BYTE_W-1:0]         req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [Z_W-1:0]     rsp_gyro_z_raw,
   output logic signed [RATE_W-1:0]  rsp_yaw_rate,
   output logic signed [PITCH_W-1:0] rsp_pitch_value
);

   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              adv;
   gfp_frame_type     frame;

   // parse the held byte when the result register can take a beat
   assign adv       = in_vld_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
   end

   gfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .byte_vld (adv),
      .byte_in  (in_byte_ff),
      .frame    (frame)
   );

   gfp_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .frame           (frame),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_gyro_z_raw  (rsp_gyro_z_raw),
      .rsp_yaw_rate    (rsp_yaw_rate),
      .rsp_pitch_value (rsp_pitch_value)
   );

`ifndef SYNTH
   a_good_needs_byte: assert property (@(posedge clock) disable iff (reset)
      frame.good |-> adv)
      else $error("frame accepted without a parsed byte");

   a_no_load_over_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !frame.good)
      else $error("result overwritten while waiting");

   a_rate_matches_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_rate == RATE_W'(rsp_gyro_z_raw * 125)))
      else $error("rate does not match raw z");

   a_pitch_matches_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_value == PITCH_W'(-(rsp_gyro_z_raw * 5))))
      else $error("pitch does not match raw z");
`endif

endmodule
